// ===== sv/s2pd_pkg.sv =====
package s2pd_pkg;

  // sizes of the stores and fields
  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 128;
  localparam int PROB_FRAC_BITS = 24;
  localparam int ENTRY_W        = PROB_FRAC_BITS + 1;
  localparam int ROW_W          = 7;
  localparam int COL_W          = 8;
  localparam int IDX_W          = 15;
  localparam int COL_DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = 2;

  // fixed point constants
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // action codes
  localparam logic [1:0] ACT_WR_ROW = 2'd0;
  localparam logic [1:0] ACT_WR_COL = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ROT    = 2'd2;

  // item passed from front end to back end
  typedef struct packed {
    logic [1:0]         action;
    logic [IDX_W-1:0]   entry_index;
    logic [ENTRY_W-1:0] cdf_value;
    logic [ENTRY_W-1:0] rand_row;
    logic [ENTRY_W-1:0] rand_col;
  } q_item_t;

  // effective configuration
  typedef struct packed {
    logic [8:0]  w;
    logic [7:0]  h;
    logic [15:0] rot;
  } cfg_t;

  // divisors of the nested sine series
  function automatic logic [6:0] sine_div(input logic [2:0] i);
    logic [6:0] d;
    case (i)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for the same divisors
  function automatic logic [29:0] sine_recip(input logic [2:0] i);
    logic [29:0] m;
    case (i)
      3'd0:    m = 30'd39045157;
      3'd1:    m = 30'd59652323;
      3'd2:    m = 30'd102261126;
      3'd3:    m = 30'd214748364;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/s2pd_if.sv =====
interface s2pd_in_if;
  import s2pd_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [IDX_W-1:0]   entry_index;
  logic [ENTRY_W-1:0] cdf_value;
  logic [ENTRY_W-1:0] rand_row;
  logic [ENTRY_W-1:0] rand_col;
  modport source (output valid, action, entry_index, cdf_value, rand_row, rand_col,
                  input ready);
  modport sink (input valid, action, entry_index, cdf_value, rand_row, rand_col,
                output ready);
endinterface

interface s2pd_out_if;
  import s2pd_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [15:0]       theta_frac;
  logic signed [15:0] phi_turns;
  logic [31:0]       density;
  modport source (output valid, found, row, col, theta_frac, phi_turns, density,
                  input ready);
  modport sink (input valid, found, row, col, theta_frac, phi_turns, density,
                output ready);
endinterface

interface s2pd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/s2pd_front.sv =====
module s2pd_front (
  s2pd_in_if.sink          in_ch,
  output logic             push_valid,
  output s2pd_pkg::q_item_t push_item,
  input  logic             push_ready
);
  import s2pd_pkg::*;

  // unknown actions are taken and dropped here
  logic known;
  assign known = (in_ch.action == ACT_WR_ROW) || (in_ch.action == ACT_WR_COL) ||
                 (in_ch.action == ACT_SAMPLE);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && known;

  // pack the item for the queue
  always_comb begin
    push_item.action      = in_ch.action;
    push_item.entry_index = in_ch.entry_index;
    push_item.cdf_value   = in_ch.cdf_value;
    push_item.rand_row    = in_ch.rand_row;
    push_item.rand_col    = in_ch.rand_col;
  end

endmodule

// ===== sv/s2pd_fifo.sv =====
module s2pd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  s2pd_pkg::q_item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output s2pd_pkg::q_item_t pop_item
);
  import s2pd_pkg::*;

  q_item_t            slot_r [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== sv/s2pd_back.sv =====
module s2pd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  s2pd_pkg::cfg_t    cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  s2pd_pkg::q_item_t pop_item,
  s2pd_out_if.source        out_ch
);
  import s2pd_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SRCH = 5'd1;
  localparam logic [4:0] S_CMP  = 5'd2;
  localparam logic [4:0] S_PREV = 5'd3;
  localparam logic [4:0] S_SDON = 5'd4;
  localparam logic [4:0] S_TH   = 5'd5;
  localparam logic [4:0] S_XF   = 5'd6;
  localparam logic [4:0] S_SF   = 5'd7;
  localparam logic [4:0] S_SX2  = 5'd8;
  localparam logic [4:0] S_SM   = 5'd9;
  localparam logic [4:0] S_ST   = 5'd10;
  localparam logic [4:0] S_SFIN = 5'd11;
  localparam logic [4:0] S_DA   = 5'd12;
  localparam logic [4:0] S_DP1  = 5'd13;
  localparam logic [4:0] S_DP2  = 5'd14;
  localparam logic [4:0] S_DN   = 5'd15;
  localparam logic [4:0] S_DQ   = 5'd16;
  localparam logic [4:0] S_DIV  = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;
  localparam logic [4:0] S_SQ   = 5'd19;

  // cdf stores
  logic [ENTRY_W-1:0] row_mem [0:MAX_HEIGHT-1];
  logic [ENTRY_W-1:0] col_mem [0:COL_DEPTH-1];
  logic [ENTRY_W-1:0] row_rd_r, col_rd_r;

  logic [4:0]         state_r, div_ret_r;
  logic [ENTRY_W-1:0] r0_r, r1_r;
  logic [8:0]         lo_r, hx_r;
  logic [7:0]         mid_r, at_r;
  logic               hit_r, phase_r;
  logic [ENTRY_W-1:0] atv_r, step_r, mdf_r, cdf_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [IDX_W-1:0]   base_r;
  logic               found_r;
  logic [15:0]        th_r, xf_r;
  logic [30:0]        x_r, term_r, s_r;
  logic [31:0]        x2_r;
  logic [2:0]         si_r;
  logic [31:0]        sn_r;
  logic [29:0]        sq_r;
  logic [49:0]        a_r;
  logic [15:0]        area_r;
  logic [40:0]        plo_r;
  logic [65:0]        n_r;
  logic [62:0]        den_r;
  logic [31:0]        dens_r;

  // shared restoring divider
  logic [63:0] div_rem_r, div_den_r;
  logic [31:0] div_lo_r, div_quo_r;
  logic [5:0]  div_cnt_r;
  logic [63:0] div_t;
  logic        div_ge;

  // output register
  logic               out_valid_r, o_found_r;
  logic [ROW_W-1:0]   o_row_r;
  logic [COL_W-1:0]   o_col_r;
  logic [15:0]        o_th_r, o_phi_r;
  logic [31:0]        o_dens_r;

  // search addressing
  logic [9:0]         mid_sum;
  logic [7:0]         mid, addr8;
  logic               srch_go;
  logic [ENTRY_W-1:0] rdata, tgt;
  logic [ROW_W-1:0]   raddr_row;
  logic [IDX_W-1:0]   raddr_col;
  logic               row_we, col_we;

  // folded angle and products
  logic [16:0] fold;
  logic [48:0] prod_f;
  logic [61:0] prod_xx, prod_xt;
  logic [62:0] prod_v;
  logic [15:0] u;

  // series term division by reciprocal with one correction step
  logic [61:0] prod_q;
  logic [36:0] prod_qd;
  logic [31:0] s_rem;
  logic [29:0] s_quo;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hx_r} - 10'd1;
  assign mid       = mid_sum[8:1];
  assign srch_go   = (lo_r < hx_r);
  assign addr8     = (state_r == S_SRCH && srch_go) ? mid : (at_r - 8'd1);
  assign raddr_row = addr8[ROW_W-1:0];
  assign raddr_col = base_r + {7'd0, addr8};
  assign rdata     = phase_r ? col_rd_r : row_rd_r;
  assign tgt       = phase_r ? r1_r : r0_r;

  assign pop_ready = (state_r == S_IDLE);
  assign row_we    = pop_valid && pop_ready && (pop_item.action == ACT_WR_ROW) &&
                     (pop_item.entry_index < IDX_W'(MAX_HEIGHT));
  assign col_we    = pop_valid && pop_ready && (pop_item.action == ACT_WR_COL) &&
                     ({1'b0, pop_item.entry_index} < (IDX_W+1)'(COL_DEPTH));

  assign div_t  = {div_rem_r[62:0], div_lo_r[31]};
  assign div_ge = (div_t >= div_den_r);

  assign fold    = (th_r > 16'd32768) ? (17'd65536 - {1'b0, th_r}) : {1'b0, th_r};
  assign prod_f  = fold * PI_Q30;
  assign prod_xx = x_r * x_r;
  assign prod_v  = x2_r * term_r;
  assign prod_xt = x_r * term_r;

  assign prod_q  = sn_r * sine_recip(si_r);
  assign prod_qd = sq_r * sine_div(si_r);
  assign s_rem   = sn_r - prod_qd[31:0];
  assign s_quo   = sq_r + {29'd0, (s_rem >= {25'd0, sine_div(si_r)})};

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (row_we) row_mem[pop_item.entry_index[ROW_W-1:0]] <= pop_item.cdf_value;
    if (col_we) col_mem[pop_item.entry_index] <= pop_item.cdf_value;
    row_rd_r <= row_mem[raddr_row];
    col_rd_r <= col_mem[raddr_col];
  end

  // sample sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop_valid && pop_item.action == ACT_SAMPLE) begin
            r0_r    <= pop_item.rand_row;
            r1_r    <= pop_item.rand_col;
            lo_r    <= '0;
            hx_r    <= {1'b0, cfg.h};
            hit_r   <= 1'b0;
            phase_r <= 1'b0;
            base_r  <= '0;
            found_r <= 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (srch_go) begin
            mid_r   <= mid;
            state_r <= S_CMP;
          end else if (!hit_r) begin
            found_r <= 1'b0;
            state_r <= S_OUT;
          end else if (at_r == 8'd0) begin
            step_r  <= atv_r;
            state_r <= S_SDON;
          end else begin
            state_r <= S_PREV;
          end
        end
        S_CMP: begin
          if (rdata >= tgt) begin
            hit_r <= 1'b1;
            at_r  <= mid_r;
            atv_r <= rdata;
            hx_r  <= {1'b0, mid_r};
          end else begin
            lo_r  <= {1'b0, mid_r} + 9'd1;
          end
          state_r <= S_SRCH;
        end
        S_PREV: begin
          step_r  <= (atv_r >= rdata) ? (atv_r - rdata) : '0;
          state_r <= S_SDON;
        end
        S_SDON: begin
          if (!phase_r) begin
            row_r   <= at_r[ROW_W-1:0];
            mdf_r   <= step_r;
            base_r  <= IDX_W'(at_r * cfg.w);
            lo_r    <= '0;
            hx_r    <= cfg.w;
            hit_r   <= 1'b0;
            phase_r <= 1'b1;
            state_r <= S_SRCH;
          end else begin
            col_r   <= at_r;
            cdf_r   <= step_r;
            state_r <= S_TH;
          end
        end
        // theta = ((2row+1)<<16 + h) / 2h
        S_TH: begin
          div_rem_r <= {56'd0, row_r, 1'b1};
          div_lo_r  <= {8'd0, cfg.h, 16'd0};
          div_den_r <= {55'd0, cfg.h, 1'b0};
          div_quo_r <= '0;
          div_cnt_r <= 6'd16;
          div_ret_r <= S_XF;
          state_r   <= S_DIV;
        end
        S_XF: begin
          th_r      <= div_quo_r[15:0];
          div_rem_r <= {55'd0, col_r, 1'b1};
          div_lo_r  <= {7'd0, cfg.w, 16'd0};
          div_den_r <= {54'd0, cfg.w, 1'b0};
          div_quo_r <= '0;
          div_cnt_r <= 6'd16;
          div_ret_r <= S_SF;
          state_r   <= S_DIV;
        end
        S_SF: begin
          xf_r    <= div_quo_r[15:0];
          x_r     <= prod_f[46:16];
          state_r <= S_SX2;
        end
        S_SX2: begin
          x2_r    <= prod_xx[61:30];
          term_r  <= ONE_Q30;
          si_r    <= '0;
          state_r <= S_SM;
        end
        // one term of the nested series
        S_SM: begin
          sn_r    <= prod_v[61:30];
          state_r <= S_SQ;
        end
        // quotient estimate, at most one short
        S_SQ: begin
          sq_r    <= prod_q[61:32];
          state_r <= S_ST;
        end
        S_ST: begin
          term_r  <= ONE_Q30 - {1'b0, s_quo};
          si_r    <= si_r + 3'd1;
          state_r <= (si_r == 3'd4) ? S_SFIN : S_SM;
        end
        S_SFIN: begin
          s_r     <= prod_xt[60:30];
          state_r <= S_DA;
        end
        S_DA: begin
          a_r     <= mdf_r * cdf_r;
          area_r  <= 16'(cfg.w * cfg.h);
          state_r <= S_DP1;
        end
        S_DP1: begin
          plo_r   <= a_r[24:0] * area_r;
          den_r   <= PI_Q30 * s_r;
          state_r <= S_DP2;
        end
        S_DP2: begin
          n_r     <= {41'(a_r[49:25] * area_r), 25'd0} + {25'd0, plo_r};
          state_r <= S_DN;
        end
        S_DN: begin
          if (s_r == '0) begin
            dens_r  <= '0;
            state_r <= S_OUT;
          end else if ({2'd0, n_r[65:5]} >= den_r) begin
            dens_r  <= 32'hFFFF_FFFF;
            state_r <= S_OUT;
          end else begin
            div_rem_r <= {3'd0, n_r[65:5]};
            div_lo_r  <= {n_r[4:0], 27'd0};
            div_den_r <= {1'b0, den_r};
            div_quo_r <= '0;
            div_cnt_r <= 6'd32;
            div_ret_r <= S_DQ;
            state_r   <= S_DIV;
          end
        end
        S_DQ: begin
          dens_r  <= div_quo_r;
          state_r <= S_OUT;
        end
        // one quotient bit a cycle
        S_DIV: begin
          div_rem_r <= div_ge ? (div_t - div_den_r) : div_t;
          div_quo_r <= {div_quo_r[30:0], div_ge};
          div_lo_r  <= {div_lo_r[30:0], 1'b0};
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd1) state_r <= div_ret_r;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_found_r   <= found_r;
            o_row_r     <= found_r ? row_r : '0;
            o_col_r     <= found_r ? col_r : '0;
            o_th_r      <= found_r ? th_r : '0;
            o_phi_r     <= found_r ? {~u[15], u[14:0]} : '0;
            o_dens_r    <= found_r ? dens_r : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // rotated azimuth
  assign u = xf_r + cfg.rot;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = o_found_r;
  assign out_ch.row        = o_row_r;
  assign out_ch.col        = o_col_r;
  assign out_ch.theta_frac = o_th_r;
  assign out_ch.phi_turns  = o_phi_r;
  assign out_ch.density    = o_dens_r;

endmodule

// ===== sv/sample_2d_piecewise_distribution_core.sv =====
// a table write leaves the queue while the sequencer is idle; a sample passes a row search
// and a column search (states S_SRCH, S_CMP per probe), the shared one-bit-a-cycle divider
// (16-, 16- and 32-bit quotients) and the sine series (S_SM, S_SQ, S_ST per term); no item
// leaves the queue until that sample is in the output register; one write per cycle while
// no sample is in flight; reset: synchronous active-low; clears queue, sequencer, output
// valid, configuration to width 256, height 128, rotation 0; cdf stores are not cleared
module sample_2d_piecewise_distribution_core (
  input logic         clk,
  input logic         rst_n,
  s2pd_in_if.sink     in_ch,
  s2pd_out_if.source  out_ch,
  s2pd_cfg_if.sink    cfg_ch
);
  import s2pd_pkg::*;

  logic [8:0]  width_r;
  logic [7:0]  height_r;
  logic [15:0] rot_r;
  cfg_t        cfg;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  q_item_t     push_item, pop_item;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 8'd128;
      rot_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_WIDTH:  width_r  <= cfg_ch.data[8:0];
        CFG_HEIGHT: height_r <= cfg_ch.data[7:0];
        CFG_ROT:    rot_r    <= cfg_ch.data;
        default:    ;
      endcase
    end
  end

  // clamp dimensions to the store sizes
  always_comb begin
    cfg.w   = (width_r == '0) ? 9'd1 :
              (width_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r;
    cfg.h   = (height_r == '0) ? 8'd1 :
              (height_r > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : height_r;
    cfg.rot = rot_r;
  end

  s2pd_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  s2pd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  s2pd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/s2pd_checker.sv =====
module s2pd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [6:0]  row,
  input logic [7:0]  col,
  input logic [15:0] theta_frac,
  input logic [15:0] phi_turns,
  input logic [31:0] density
);

  // a waiting item stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a miss carries an all-zero payload
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> row == '0 && col == '0 && theta_frac == '0 &&
                            phi_turns == '0 && density == '0)
    else $error("miss with nonzero payload");

  // a hit lies at least half a row below the pole
  a_theta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> theta_frac >= 16'd256)
    else $error("theta below half a row");

  // nothing is offered right after reset
  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind sample_2d_piecewise_distribution_core s2pd_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .found      (out_ch.found),
  .row        (out_ch.row),
  .col        (out_ch.col),
  .theta_frac (out_ch.theta_frac),
  .phi_turns  (out_ch.phi_turns),
  .density    (out_ch.density)
);

// ===== tb/s2pd_checker.sv =====
`timescale 1ns / 100ps

module s2pd_scoreboard (
  input  logic clk,
  input  logic rst_n,
  s2pd_in_if   in_ch,
  s2pd_out_if  out_ch,
  s2pd_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  import s2pd_pkg::*;

  typedef struct {
    logic        found;
    logic [6:0]  row;
    logic [7:0]  col;
    logic [15:0] theta_frac;
    logic [15:0] phi_turns;
    logic [31:0] density;
  } draw_t;

  draw_t draws_due[$];

  logic [ENTRY_W-1:0] row_cdf[MAX_HEIGHT];
  logic [ENTRY_W-1:0] col_cdf[COL_DEPTH];
  logic [8:0]  width_reg;
  logic [7:0]  height_reg;
  logic [15:0] rot_reg;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // sin(pi*t/65536) in Q30, nested odd series on the folded angle
  function automatic logic [63:0] sine_of_theta(input logic [15:0] t);
    logic [63:0] f, x, x2, term;
    int i;
    f = (t > 16'd32768) ? 64'd65536 - 64'(t) : 64'(t);
    x = (f * 64'(PI_Q30)) >> 16;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    for (i = 0; i < 5; i++)
      term = (64'd1 << 30) - ((x2 * term) >> 30) / 64'(sine_div(3'(i)));
    return (x * term) >> 30;
  endfunction

  // first entry not less than r; step is the entry minus the one before, floored at 0
  function automatic bit cdf_lookup(input bit on_rows, input int base, input int count,
                                    input logic [24:0] r, output int at,
                                    output logic [24:0] step);
    int lo, hi, mid;
    bit hit;
    logic [24:0] cur, prev;
    lo = 0;
    hi = count - 1;
    hit = 0;
    at = 0;
    step = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      cur = on_rows ? row_cdf[mid] : col_cdf[base + mid];
      if (cur >= r) begin
        hit = 1;
        at = mid;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    if (hit) begin
      cur = on_rows ? row_cdf[at] : col_cdf[base + at];
      if (at == 0) begin
        step = cur;
      end else begin
        prev = on_rows ? row_cdf[at-1] : col_cdf[base + at - 1];
        step = (cur >= prev) ? cur - prev : '0;
      end
    end
    return hit;
  endfunction

  // density in Q17.15, saturating
  function automatic logic [31:0] density_of(input logic [24:0] mdf, input logic [24:0] cdf,
                                             input int area, input logic [63:0] s);
    logic [127:0] num, den, q;
    if (s == 0) return '0;
    num = (128'(mdf) * 128'(cdf) * 128'(area)) << (75 - 2 * PROB_FRAC_BITS);
    den = 128'(PI_Q30) * 128'(s);
    q = num / den;
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic draw_t draw_of(input logic [24:0] r0, input logic [24:0] r1);
    draw_t d;
    int w, h, row, col;
    logic [24:0] mdf, cdf;
    logic [63:0] th, xf, u;
    d = '{default: '0};
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    if (!cdf_lookup(1'b1, 0, h, r0, row, mdf)) return d;
    if (!cdf_lookup(1'b0, row * w, w, r1, col, cdf)) return d;
    th = ((64'(2 * row + 1) << 16) + 64'(h)) / (64'd2 * 64'(h));
    xf = ((64'(2 * col + 1) << 16) + 64'(w)) / (64'd2 * 64'(w));
    u = (xf + 64'(rot_reg)) & 64'hFFFF;
    d.found = 1'b1;
    d.row = row[6:0];
    d.col = col[7:0];
    d.theta_frac = th[15:0];
    d.phi_turns = u[15:0] ^ 16'h8000;
    d.density = density_of(mdf, cdf, w * h, sine_of_theta(th[15:0]));
    return d;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // track configuration and tables, predict draws, check results in order
  always @(posedge clk) begin
    draw_t want;
    if (!rst_n) begin
      width_reg  = 9'd256;
      height_reg = 8'd128;
      rot_reg    = 16'd0;
      draws_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (draws_due.size() == 0) begin
          $error("result item with no draw pending");
          fail_count++;
        end else begin
          want = draws_due.pop_front();
          compare_field("found", 32'(want.found), 32'(out_ch.found));
          compare_field("row", 32'(want.row), 32'(out_ch.row));
          compare_field("col", 32'(want.col), 32'(out_ch.col));
          compare_field("theta_frac", 32'(want.theta_frac), 32'(out_ch.theta_frac));
          compare_field("phi_turns", 32'(want.phi_turns), {16'd0, out_ch.phi_turns});
          compare_field("density", want.density, out_ch.density);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_WIDTH:  width_reg  = cfg_ch.data[8:0];
          CFG_HEIGHT: height_reg = cfg_ch.data[7:0];
          CFG_ROT:    rot_reg    = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.action)
          ACT_WR_ROW:
            if (in_ch.entry_index < MAX_HEIGHT) row_cdf[in_ch.entry_index] = in_ch.cdf_value;
          ACT_WR_COL:
            if (in_ch.entry_index < COL_DEPTH) col_cdf[in_ch.entry_index] = in_ch.cdf_value;
          ACT_SAMPLE:
            draws_due.push_back(draw_of(in_ch.rand_row, in_ch.rand_col));
          default: ;
        endcase
      end
    end
    pending = draws_due.size();
  end

endmodule

// ===== tb/sample_2d_piecewise_distribution_core_tb.sv =====
`timescale 1ns / 100ps

module sample_2d_piecewise_distribution_core_tb;
  import s2pd_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int PROB_ONE = 1 << PROB_FRAC_BITS;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit gaps_on = 1;
  bit hold_now = 0;
  int cur_w, cur_h;

  s2pd_in_if  in_ch();
  s2pd_out_if out_ch();
  s2pd_cfg_if cfg_ch();

  sample_2d_piecewise_distribution_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  s2pd_scoreboard draw_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_uniform();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return PROB_ONE;
      default: return $urandom_range(0, PROB_ONE);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] act, input int idx, input int val,
                           input int r0, input int r1);
    int g;
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.entry_index <= idx[IDX_W-1:0];
    in_ch.cdf_value   <= val[ENTRY_W-1:0];
    in_ch.rand_row    <= r0[ENTRY_W-1:0];
    in_ch.rand_col    <= r1[ENTRY_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[15:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(input int w, input int h, input int rot);
    wait_drained();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_ROT, rot);
    cur_w = (w[8:0] == 0) ? 1 : (w[8:0] > MAX_WIDTH) ? MAX_WIDTH : int'(w[8:0]);
    cur_h = (h[7:0] == 0) ? 1 : (h[7:0] > MAX_HEIGHT) ? MAX_HEIGHT : int'(h[7:0]);
  endtask

  // one cumulative table: mostly monotone up to one, sometimes short, flat or scrambled
  task automatic fill_cdf(input logic [1:0] act, input int base, input int n);
    int mode, acc, val, i;
    mode = $urandom_range(0, 9);
    acc = 0;
    for (i = 0; i < n; i++) begin
      if (mode == 8) begin
        val = $urandom_range(0, PROB_ONE);
      end else begin
        if (!(mode == 9 && $urandom_range(0, 1))) acc += $urandom_range(0, 2 * PROB_ONE / n);
        if (acc > PROB_ONE) acc = PROB_ONE;
        if (i == n - 1 && mode < 7) acc = PROB_ONE;
        val = acc;
      end
      send_item(act, base + i, val, $urandom_range(0, PROB_ONE), $urandom_range(0, PROB_ONE));
    end
  endtask

  task automatic fill_tables();
    int r;
    fill_cdf(ACT_WR_ROW, 0, cur_h);
    for (r = 0; r < cur_h; r++) fill_cdf(ACT_WR_COL, r * cur_w, cur_w);
  endtask

  // marginal reaching one within the first rows, so only those rows need tables
  task automatic fill_top_rows(input int reach);
    int i, r;
    for (i = 0; i < cur_h; i++)
      send_item(ACT_WR_ROW, i, (i < reach - 1) ? (i + 1) * (PROB_ONE / reach) : PROB_ONE,
                0, 0);
    for (r = 0; r < reach; r++) fill_cdf(ACT_WR_COL, r * cur_w, cur_w);
  endtask

  // draws with some ignored and harmless writes mixed in
  task automatic draw_run(input int n);
    int i, k;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        k = $urandom_range(0, 2);
        if (k == 0)
          send_item(ACT_IGNORED, $urandom_range(0, 32767), $urandom_range(0, PROB_ONE),
                    $urandom_range(0, PROB_ONE), $urandom_range(0, PROB_ONE));
        else if (k == 1)
          send_item(ACT_WR_ROW, $urandom_range(MAX_HEIGHT, 32767),
                    $urandom_range(0, PROB_ONE), 0, 0);
        else
          send_item(ACT_WR_COL, $urandom_range(0, cur_w * cur_h - 1),
                    $urandom_range(0, PROB_ONE), 0, 0);
      end
      send_item(ACT_SAMPLE, $urandom_range(0, 32767), $urandom_range(0, PROB_ONE),
                pick_uniform(), pick_uniform());
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_now) begin
        hold_now = 0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      g = gaps_on ? gap_len() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int p;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_WR_ROW;
    in_ch.entry_index <= '0;
    in_ch.cdf_value   <= '0;
    in_ch.rand_row    <= '0;
    in_ch.rand_col    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_WIDTH;
    cfg_ch.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single cell with zero sizes clamped to one, full rotation
    set_shape(0, 0, 65535);
    send_item(ACT_WR_ROW, 0, PROB_ONE, 0, 0);
    send_item(ACT_WR_COL, 0, 0, 0, 0);
    send_item(ACT_SAMPLE, 0, 0, 0, 0);
    send_item(ACT_SAMPLE, 32767, PROB_ONE, PROB_ONE, PROB_ONE);
    send_item(ACT_WR_COL, 0, 5, 0, 0);
    send_item(ACT_SAMPLE, 0, 0, 1, 6);
    send_item(ACT_SAMPLE, 0, 0, 1, 5);
    send_item(ACT_WR_ROW, 0, 0, 0, 0);
    send_item(ACT_SAMPLE, 0, 0, 1, 0);
    send_item(ACT_IGNORED, 32767, PROB_ONE, PROB_ONE, PROB_ONE);
    send_item(ACT_WR_ROW, 32767, PROB_ONE, 0, 0);
    send_item(ACT_WR_ROW, 0, PROB_ONE, 0, 0);
    send_item(ACT_SAMPLE, 0, 0, PROB_ONE, 5);

    // widest shape, width above range
    set_shape(511, 1, 0);
    fill_tables();
    draw_run(10);

    // tallest shape, height above range, mass in the first rows only
    set_shape(1, 200, 32768);
    fill_top_rows(8);
    draw_run(10);

    // random small shapes
    for (p = 0; p < 3; p++) begin
      gaps_on = (p != 2);
      set_shape($urandom_range(1, 8), $urandom_range(1, 9), $urandom_range(0, 65535));
      fill_tables();
      if (p == 1) begin
        gaps_on = 0;
        hold_now = 1;
        draw_run(25);
      end else begin
        draw_run(12);
      end
    end
    gaps_on = 1;

    wait_drained();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
